@@ sv/rnlw_pkg.sv @@
package rnlw_pkg;

  // Largest value shown; larger inputs are clamped to it
  localparam logic [11:0] ValueLimit = 12'd2099;

  // Symbol codes as they appear on symbol_code_o; SymNone marks no second symbol
  typedef enum logic [2:0] {
    SymI    = 3'd0,
    SymV    = 3'd1,
    SymX    = 3'd2,
    SymL    = 3'd3,
    SymM    = 3'd4,
    SymNone = 3'd7
  } sym_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegColourI = 3'd0,
    RegColourV = 3'd1,
    RegColourX = 3'd2,
    RegColourL = 3'd3,
    RegColourM = 3'd4
  } reg_e;

  // One row of the greedy table
  typedef struct packed {
    logic [9:0] weight;
    sym_e       first;
    sym_e       second;
  } rn_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } rnlw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_nonzero;
    logic slot_free;
    logic step_last;
  } rnlw_sts_t;

  // Largest table entry not above the remaining value (value must be nonzero)
  function automatic rn_entry_t rn_pick(logic [11:0] rem);
    rn_entry_t e;
    if (rem >= 12'd1000)    e = '{weight: 10'd1000, first: SymM, second: SymNone};
    else if (rem >= 12'd50) e = '{weight: 10'd50,   first: SymL, second: SymNone};
    else if (rem >= 12'd40) e = '{weight: 10'd40,   first: SymX, second: SymL};
    else if (rem >= 12'd10) e = '{weight: 10'd10,   first: SymX, second: SymNone};
    else if (rem >= 12'd9)  e = '{weight: 10'd9,    first: SymI, second: SymX};
    else if (rem >= 12'd5)  e = '{weight: 10'd5,    first: SymV, second: SymNone};
    else if (rem >= 12'd4)  e = '{weight: 10'd4,    first: SymI, second: SymV};
    else                    e = '{weight: 10'd1,    first: SymI, second: SymNone};
    return e;
  endfunction

endpackage

@@ sv/roman_numeral_led_writer.sv @@
// Roman numeral LED writer. Each input request carries a number and a starting
// LED index; the number (clamped to 2099) is converted by greedy subtraction
// over M=1000, L=50, XL=40, X=10, IX=9, V=5, IV=4, I=1 (no C or D, hundreds
// appear as runs of L), and one LED write per symbol letter is produced, with
// the index counting up from first_led_i modulo 256 and the colour taken from
// that letter's register. The final write of a number has is_last_o set; a
// zero value produces no writes. An input request is first loaded into the
// conversion registers, then converted one symbol per cycle whenever output
// backpressure allows, with 1988 giving the worst case of 27 writes. The next
// request is taken as soon as the last symbol
// has entered the output register. Colour registers (index 0..4 = I, V, X, L,
// M) are written through the configuration port, which is always ready.
module roman_numeral_led_writer
  import rnlw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] value_i,
  input  logic [7:0]  first_led_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  led_index_o,
  output logic [23:0] led_colour_o,
  output logic [2:0]  symbol_code_o,
  output logic        is_last_o
);

  rnlw_cmd_t cmd;
  rnlw_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rnlw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rnlw_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .first_led_i   (first_led_i),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .led_index_o   (led_index_o),
    .led_colour_o  (led_colour_o),
    .symbol_code_o (symbol_code_o),
    .is_last_o     (is_last_o)
  );

endmodule

@@ sv/rnlw_ctrl.sv @@
module rnlw_ctrl
  import rnlw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rnlw_sts_t sts_i,
  output rnlw_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Request taken only between numbers
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.emit = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_nonzero) state_d = StRun;
        end
      end
      StRun: begin
        // one symbol per cycle whenever the output slot is free
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.step_last) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/rnlw_dp.sv @@
module rnlw_dp
  import rnlw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rnlw_cmd_t   cmd_i,
  output rnlw_sts_t   sts_o,
  input  logic [11:0] value_i,
  input  logic [7:0]  first_led_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  led_index_o,
  output logic [23:0] led_colour_o,
  output logic [2:0]  symbol_code_o,
  output logic        is_last_o
);

  logic [23:0] colour_i_q, colour_v_q, colour_x_q, colour_l_q, colour_m_q;
  logic [11:0] rem_q, rem_d;
  logic [7:0]  led_q;
  sym_e        pend_q, pend_d;
  sym_e        cur_sym;
  logic [23:0] cur_colour;
  logic [11:0] value_clamped;
  rn_entry_t   pick;
  logic        out_valid_q;
  logic [7:0]  out_index_q;
  logic [23:0] out_colour_q;
  logic [2:0]  out_sym_q;
  logic        out_last_q;

  // Colour registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_i_q <= '0;
      colour_v_q <= '0;
      colour_x_q <= '0;
      colour_l_q <= '0;
      colour_m_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegColourI: colour_i_q <= cfg_data_i;
        RegColourV: colour_v_q <= cfg_data_i;
        RegColourX: colour_x_q <= cfg_data_i;
        RegColourL: colour_l_q <= cfg_data_i;
        RegColourM: colour_m_q <= cfg_data_i;
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  assign value_clamped = (value_i > ValueLimit) ? ValueLimit : value_i;

  // Next symbol: a pending second symbol first, else the greedy table
  always_comb begin
    pick = rn_pick(rem_q);
    if (pend_q != SymNone) begin
      cur_sym = pend_q;
      rem_d   = rem_q;
      pend_d  = SymNone;
    end else begin
      cur_sym = pick.first;
      rem_d   = rem_q - {2'b00, pick.weight};
      pend_d  = pick.second;
    end
  end

  always_comb begin
    case (cur_sym)
      SymI:    cur_colour = colour_i_q;
      SymV:    cur_colour = colour_v_q;
      SymX:    cur_colour = colour_x_q;
      SymL:    cur_colour = colour_l_q;
      SymM:    cur_colour = colour_m_q;
      default: cur_colour = '0;
    endcase
  end

  // Conversion state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      led_q  <= '0;
      pend_q <= SymNone;
    end else if (cmd_i.load) begin
      rem_q  <= value_clamped;
      led_q  <= first_led_i;
      pend_q <= SymNone;
    end else if (cmd_i.emit) begin
      rem_q  <= rem_d;
      led_q  <= led_q + 8'd1;
      pend_q <= pend_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_index_q  <= led_q;
      out_colour_q <= cur_colour;
      out_sym_q    <= cur_sym;
      out_last_q   <= sts_o.step_last;
    end
  end

  assign sts_o.in_nonzero = (value_i != 12'd0);
  assign sts_o.slot_free  = !out_valid_q || out_ready_i;
  assign sts_o.step_last  = (rem_d == 12'd0) && (pend_d == SymNone);

  assign out_valid_o   = out_valid_q;
  assign led_index_o   = out_index_q;
  assign led_colour_o  = out_colour_q;
  assign symbol_code_o = out_sym_q;
  assign is_last_o     = out_last_q;

  // Checks
  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (rem_q != 12'd0 || pend_q != SymNone))
    else $error("symbol emitted with nothing left to convert");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (pend_q == SymNone))
    else $error("new number loaded while a second symbol is pending");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && sts_o.step_last) |=> (rem_q == 12'd0 && pend_q == SymNone))
    else $error("final write marked but conversion not finished");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= ValueLimit)
    else $error("remaining value above clamp limit");

endmodule
